### sv/idmat_pkg.sv
// ----------------------------------------------------------------------------
// idmat_pkg
// Shared types and constants for the id/MAC address table.
// ----------------------------------------------------------------------------
package idmat_pkg;

  localparam int ENTRIES = 1024;
  localparam int IDX_W   = $clog2(ENTRIES);
  localparam int CNT_W   = IDX_W + 1;

  localparam logic [31:0] PERM_STAMP = 32'hFFFF_FFFF;

  typedef enum logic [2:0] {
    FN_LOOKUP_ID  = 3'd0,
    FN_LOOKUP_MAC = 3'd1,
    FN_ADD        = 3'd2,
    FN_UPDATE     = 3'd3,
    FN_SET_PERM   = 3'd4,
    FN_DELETE     = 3'd5,
    FN_CLEAR      = 3'd6,
    FN_NONE       = 3'd7
  } func_t;

  typedef struct packed {
    logic [2:0]  func;
    logic [31:0] key_id;
    logic [47:0] key_mac;
    logic [15:0] new_sid;
    logic        sid_present;
    logic        make_permanent;
  } cmd_t;

  typedef struct packed {
    logic        found;
    logic [31:0] hit_id;
    logic [47:0] hit_mac;
    logic [15:0] hit_sid;
  } rsp_t;

  typedef struct packed {
    logic [31:0] id;
    logic [47:0] mac;
    logic [15:0] sid;
    logic [31:0] stamp;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

endpackage

### sv/id_mac_address_table_top.sv
// ----------------------------------------------------------------------------
// id_mac_address_table_top
// Id/MAC address table with first-match lookup and oldest-entry replacement.
// ----------------------------------------------------------------------------
//  channel   ports                     handshake
//  command   start, busy, cmd (cmd_t)  word taken when start & !busy
//  response  done, rsp (rsp_t)         word valid for the single cycle of done
//
//  Every command but clear scans all ENTRIES entries through the single read
//  port of the entry RAM.
//  Clear all writes zeros one entry a cycle.
//  After reset a clearing pass over all ENTRIES entries runs with busy high.
//  The receiver cannot stall; busy holds off the next command until done.
// ----------------------------------------------------------------------------
module id_mac_address_table_top (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  idmat_pkg::cmd_t   cmd,
  output logic              done,
  output idmat_pkg::rsp_t   rsp
);

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_INIT  = 5'b00010,
    ST_SCAN  = 5'b00100,
    ST_WRITE = 5'b01000,
    ST_CLEAR = 5'b10000
  } state_t;

  state_t                       state;
  logic [idmat_pkg::CNT_W-1:0]  cnt;
  logic                         pipe_vld;
  logic [idmat_pkg::IDX_W-1:0]  pipe_idx;
  idmat_pkg::cmd_t              cmd_q;
  logic [31:0]                  age;

  logic                         id_hit;
  idmat_pkg::entry_t            id_ent;
  logic [idmat_pkg::IDX_W-1:0]  id_idx;
  logic                         mac_hit;
  idmat_pkg::entry_t            mac_ent;
  logic                         zero_hit;
  idmat_pkg::entry_t            zero_ent;
  logic [idmat_pkg::IDX_W-1:0]  zero_idx;
  idmat_pkg::entry_t            cand_ent;
  logic [idmat_pkg::IDX_W-1:0]  cand_idx;

  logic                         ram_we;
  logic [idmat_pkg::IDX_W-1:0]  ram_waddr;
  idmat_pkg::entry_t            ram_wdata;
  logic [idmat_pkg::IDX_W-1:0]  ram_raddr;
  idmat_pkg::entry_t            ram_rdata;

  logic                         scan_issue;
  logic                         sweep_last;
  logic                         cand_older;
  logic [31:0]                  age_inc;
  logic [31:0]                  age_next;
  idmat_pkg::entry_t            tgt_ent;
  logic [idmat_pkg::IDX_W-1:0]  tgt_idx;
  idmat_pkg::rsp_t              wr_rsp;

  idmat_ram #(
    .WIDTH (idmat_pkg::ENTRY_W),
    .DEPTH (idmat_pkg::ENTRIES)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign busy       = (state != ST_IDLE);
  assign scan_issue = (state == ST_SCAN) && (cnt < idmat_pkg::CNT_W'(idmat_pkg::ENTRIES));
  assign sweep_last = (cnt == idmat_pkg::CNT_W'(idmat_pkg::ENTRIES - 1));
  assign ram_raddr  = cnt[idmat_pkg::IDX_W-1:0];

  // candidate is after the incoming entry under wraparound: take the entry
  always_comb begin
    logic [31:0] diff;
    diff       = ram_rdata.stamp - cand_ent.stamp;
    cand_older = diff[31];
  end

  always_comb begin
    age_inc  = age + 32'd1;
    age_next = (age_inc == idmat_pkg::PERM_STAMP) ? 32'd0 : age_inc;
  end

  // target of add: same id, else first free, else oldest
  always_comb begin
    if (id_hit) begin
      tgt_ent = id_ent;
      tgt_idx = id_idx;
    end else if (zero_hit) begin
      tgt_ent = zero_ent;
      tgt_idx = zero_idx;
    end else begin
      tgt_ent = cand_ent;
      tgt_idx = cand_idx;
    end
  end

  always_comb begin
    wr_rsp = '0;
    case (cmd_q.func) inside
      idmat_pkg::FN_LOOKUP_ID: begin
        if (id_hit) begin
          wr_rsp = '{1'b1, id_ent.id, id_ent.mac, id_ent.sid};
        end
      end
      idmat_pkg::FN_LOOKUP_MAC: begin
        if (mac_hit) begin
          wr_rsp = '{1'b1, mac_ent.id, mac_ent.mac, mac_ent.sid};
        end
      end
      idmat_pkg::FN_ADD: begin
        wr_rsp.found = 1'b1;
      end
      idmat_pkg::FN_UPDATE, idmat_pkg::FN_SET_PERM, idmat_pkg::FN_DELETE: begin
        wr_rsp.found = id_hit;
      end
      default: begin
        wr_rsp = '0;
      end
    endcase
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = cnt[idmat_pkg::IDX_W-1:0];
    ram_wdata = '0;
    unique case (state) inside
      ST_INIT, ST_CLEAR: begin
        ram_we = 1'b1;
      end
      ST_WRITE: begin
        unique case (cmd_q.func)
          idmat_pkg::FN_ADD: begin
            ram_we        = 1'b1;
            ram_waddr     = tgt_idx;
            ram_wdata.id  = cmd_q.key_id;
            ram_wdata.mac = cmd_q.key_mac;
            ram_wdata.sid = cmd_q.sid_present ? cmd_q.new_sid : tgt_ent.sid;
            if (tgt_ent.stamp == idmat_pkg::PERM_STAMP || cmd_q.make_permanent) begin
              ram_wdata.stamp = idmat_pkg::PERM_STAMP;
            end else begin
              ram_wdata.stamp = age_next;
            end
          end
          idmat_pkg::FN_UPDATE: begin
            ram_we        = id_hit;
            ram_waddr     = id_idx;
            ram_wdata     = id_ent;
            ram_wdata.mac = cmd_q.key_mac;
            ram_wdata.sid = cmd_q.new_sid;
          end
          idmat_pkg::FN_SET_PERM: begin
            ram_we          = id_hit && cmd_q.make_permanent;
            ram_waddr       = id_idx;
            ram_wdata       = id_ent;
            ram_wdata.stamp = idmat_pkg::PERM_STAMP;
          end
          idmat_pkg::FN_DELETE: begin
            ram_we    = id_hit;
            ram_waddr = id_idx;
          end
          default: begin
            ram_we = 1'b0;
          end
        endcase
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_INIT;
      cnt      <= '0;
      pipe_vld <= 1'b0;
      age      <= '0;
      done     <= 1'b0;
    end else begin
      done     <= (state == ST_WRITE) || ((state == ST_CLEAR) && sweep_last);
      pipe_vld <= scan_issue;
      unique case (state)
        ST_IDLE: begin
          cnt <= '0;
          if (start) begin
            cmd_q    <= cmd;
            id_hit   <= 1'b0;
            mac_hit  <= 1'b0;
            zero_hit <= 1'b0;
            state    <= (cmd.func == idmat_pkg::FN_CLEAR) ? ST_CLEAR : ST_SCAN;
          end
        end
        ST_INIT: begin
          cnt <= cnt + idmat_pkg::CNT_W'(1);
          if (sweep_last) begin
            state <= ST_IDLE;
          end
        end
        ST_CLEAR: begin
          cnt <= cnt + idmat_pkg::CNT_W'(1);
          if (sweep_last) begin
            rsp   <= '0;
            state <= ST_IDLE;
          end
        end
        ST_SCAN: begin
          if (scan_issue) begin
            cnt <= cnt + idmat_pkg::CNT_W'(1);
          end
          if (pipe_vld) begin
            if (!id_hit && ram_rdata.id == cmd_q.key_id) begin
              id_hit <= 1'b1;
              id_ent <= ram_rdata;
              id_idx <= pipe_idx;
            end
            if (!mac_hit && ram_rdata.mac == cmd_q.key_mac) begin
              mac_hit <= 1'b1;
              mac_ent <= ram_rdata;
            end
            if (!zero_hit && ram_rdata.id == 32'd0) begin
              zero_hit <= 1'b1;
              zero_ent <= ram_rdata;
              zero_idx <= pipe_idx;
            end
            if (pipe_idx == '0 || cand_older) begin
              cand_ent <= ram_rdata;
              cand_idx <= pipe_idx;
            end
            if (pipe_idx == idmat_pkg::IDX_W'(idmat_pkg::ENTRIES - 1)) begin
              state <= ST_WRITE;
            end
          end
        end
        ST_WRITE: begin
          rsp   <= wr_rsp;
          state <= ST_IDLE;
          // advance the stamp only when a fresh stamp is written
          if (cmd_q.func == idmat_pkg::FN_ADD &&
              tgt_ent.stamp != idmat_pkg::PERM_STAMP && !cmd_q.make_permanent) begin
            age <= age_next;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    pipe_idx <= cnt[idmat_pkg::IDX_W-1:0];
  end

endmodule

### sv/idmat_ram.sv
// ----------------------------------------------------------------------------
// idmat_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module idmat_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
